@@ hw/rtl/lpc_pkg.sv @@
// lpc_pkg: shared types and constants for the led pattern controller
// used by lpc_phase_div, lpc_slot_alu and led_pattern_controller
// no dependencies
package lpc_pkg;

    localparam int SLOT_COUNT  = 8;
    localparam int SLOT_W      = 3;
    localparam int MODE_W      = 3;
    localparam int FLASH_W     = 3;
    localparam int LEVEL_W     = 8;
    localparam int TIME_W      = 32;

    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SLOW   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FAST   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BREATH = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FLASH  = 3'd5;

    localparam int SLOW_HALF     = 500;
    localparam int FAST_HALF     = 100;
    localparam int BREATH_MS     = 15;
    localparam int BREATH_STEP   = 5;
    localparam int LEVEL_MAX     = 255;
    localparam int FLASH_TOGGLES = 6;

    // x = now/4 (below 2^30): (x * K) >> S gives x/125 = now/500 and x/25 = now/100
    localparam int RECIP_X_W = TIME_W - 2;
    localparam int RECIP_K_W = 31;
    localparam int RECIP_P_W = RECIP_X_W + RECIP_K_W;
    localparam logic [RECIP_K_W-1:0] SLOW_RECIP    = 31'd1099511628;
    localparam int                   SLOW_RECIP_SH = 37;
    localparam logic [RECIP_K_W-1:0] FAST_RECIP    = 31'd1374389535;
    localparam int                   FAST_RECIP_SH = 35;

    localparam logic KIND_DRIVE = 1'b0;
    localparam logic KIND_ACK   = 1'b1;
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_SET    = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    localparam int REG_PRESENT  = 0;
    localparam int REG_DIMMABLE = 1;
    localparam int REG_STATIC   = 2;
    localparam int PADDR_W      = 4;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 24;

    // bit 0 of now/500 and now/100
    typedef struct packed {
        logic slow_odd;
        logic fast_odd;
    } phase_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TIME_W-1:0]  last_time;
        logic [FLASH_W-1:0] flash;
        logic [LEVEL_W-1:0] level;
        logic               rising;
    } slot_state_t;

    typedef struct packed {
        logic               wr;
        logic               on;
        logic               bw;
        logic [LEVEL_W-1:0] br;
    } drive_t;

endpackage

@@ hw/rtl/lpc_phase_div.sv @@
// lpc_phase_div: parity of now/500 and now/100 by reciprocal multiplication
// one shared multiplier, used in turn: slow quotient first, then fast
// depends on lpc_pkg
module lpc_phase_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lpc_pkg::TIME_W-1:0] now_ms,
    output logic                       busy,
    output lpc_pkg::phase_t            phase
);

    logic                            busy_reg;
    logic                            fast_sel_reg;
    logic [lpc_pkg::RECIP_X_W-1:0]   x_reg;
    logic                            slow_odd_reg;
    logic                            fast_odd_reg;
    logic [lpc_pkg::RECIP_K_W-1:0]   recip;
    logic [lpc_pkg::RECIP_P_W-1:0]   product;

    assign recip   = fast_sel_reg ? lpc_pkg::FAST_RECIP : lpc_pkg::SLOW_RECIP;
    assign product = {{lpc_pkg::RECIP_K_W{1'b0}}, x_reg}
                   * {{lpc_pkg::RECIP_X_W{1'b0}}, recip};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            fast_sel_reg <= 1'b0;
        end else if (start) begin
            busy_reg     <= 1'b1;
            fast_sel_reg <= 1'b0;
        end else if (busy_reg) begin
            fast_sel_reg <= 1'b1;
            if (fast_sel_reg) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= now_ms[lpc_pkg::TIME_W-1:2];
        end else if (busy_reg) begin
            if (fast_sel_reg) begin
                fast_odd_reg <= product[lpc_pkg::FAST_RECIP_SH];
            end else begin
                slow_odd_reg <= product[lpc_pkg::SLOW_RECIP_SH];
            end
        end
    end

    assign busy           = busy_reg;
    assign phase.slow_odd = slow_odd_reg;
    assign phase.fast_odd = fast_odd_reg;

endmodule

@@ hw/rtl/lpc_slot_alu.sv @@
// lpc_slot_alu: shared per-slot step, one slot per use
// elapsed-time compare, blink, breathing and flash logic
// depends on lpc_pkg
module lpc_slot_alu (
    input  logic                       present,
    input  logic                       dimmable,
    input  logic [lpc_pkg::TIME_W-1:0] now_ms,
    input  lpc_pkg::phase_t            phase,
    input  lpc_pkg::slot_state_t       cur,
    output lpc_pkg::slot_state_t       nxt,
    output lpc_pkg::drive_t            drive
);

    logic [lpc_pkg::TIME_W-1:0]  elapsed;
    logic [lpc_pkg::LEVEL_W:0]   level_up;

    assign elapsed  = now_ms - cur.last_time;
    assign level_up = {1'b0, cur.level} + (lpc_pkg::LEVEL_W+1)'(lpc_pkg::BREATH_STEP);

    always_comb begin
        nxt   = cur;
        drive = '0;
        if (present) begin
            unique case (cur.mode)
                lpc_pkg::MODE_OFF: begin
                    drive.wr = 1'b1;
                end
                lpc_pkg::MODE_ON: begin
                    drive.wr = 1'b1;
                    drive.on = 1'b1;
                end
                lpc_pkg::MODE_SLOW: begin
                    if (elapsed >= lpc_pkg::TIME_W'(lpc_pkg::SLOW_HALF)) begin
                        drive.wr      = 1'b1;
                        drive.on      = phase.slow_odd;
                        nxt.last_time = now_ms;
                    end
                end
                lpc_pkg::MODE_FAST: begin
                    if (elapsed >= lpc_pkg::TIME_W'(lpc_pkg::FAST_HALF)) begin
                        drive.wr      = 1'b1;
                        drive.on      = phase.fast_odd;
                        nxt.last_time = now_ms;
                    end
                end
                lpc_pkg::MODE_BREATH: begin
                    if (dimmable && elapsed >= lpc_pkg::TIME_W'(lpc_pkg::BREATH_MS)) begin
                        if (cur.rising) begin
                            if (level_up >= (lpc_pkg::LEVEL_W+1)'(lpc_pkg::LEVEL_MAX)) begin
                                nxt.level  = lpc_pkg::LEVEL_W'(lpc_pkg::LEVEL_MAX);
                                nxt.rising = 1'b0;
                            end else begin
                                nxt.level = level_up[lpc_pkg::LEVEL_W-1:0];
                            end
                        end else if (cur.level != '0) begin
                            if (cur.level >= lpc_pkg::LEVEL_W'(lpc_pkg::BREATH_STEP)) begin
                                nxt.level = cur.level - lpc_pkg::LEVEL_W'(lpc_pkg::BREATH_STEP);
                            end else begin
                                nxt.level = '0;
                            end
                        end else begin
                            // bottom reached: turn around without a step
                            nxt.rising = 1'b1;
                        end
                        drive.wr      = 1'b1;
                        drive.bw      = 1'b1;
                        drive.br      = nxt.level;
                        nxt.last_time = now_ms;
                    end
                end
                lpc_pkg::MODE_FLASH: begin
                    if (cur.flash >= lpc_pkg::FLASH_W'(lpc_pkg::FLASH_TOGGLES)) begin
                        nxt.mode  = lpc_pkg::MODE_OFF;
                        nxt.flash = '0;
                        drive.wr  = 1'b1;
                    end else if (elapsed >= lpc_pkg::TIME_W'(lpc_pkg::FAST_HALF)) begin
                        drive.wr      = 1'b1;
                        drive.on      = cur.flash[0];
                        nxt.last_time = now_ms;
                        nxt.flash     = cur.flash + 1'b1;
                    end
                end
                default: begin
                    // unknown mode: held, nothing driven
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/led_pattern_controller.sv @@
// led_pattern_controller: top level, sequencer, slot storage, apb registers
// and the output register; uses lpc_phase_div and lpc_slot_alu
// depends on lpc_pkg
//
//  channel   dir   handshake               payload
//  s_axis    in    s_tvalid / s_tready     tdata: now_ms, slot_id, new_mode; tuser: func
//  m_axis    out   m_tvalid / m_tready     tdata: result fields; tuser: kind; tlast: last
//  apb       in    psel, penable, pready   paddr, pwdata, prdata
//
// a set-mode item is accepted, then acknowledged from the set state once the output is free.
// an update item steps through acceptance, the shared multiplier
// (now/500, then now/100), a hand-over, then the slot step for each slot in turn.
// s_tready is high only while idle; a stalled m_tready holds the sequencer.
// reset (synchronous, active low) clears all slot state, the apb registers and control.
module led_pattern_controller (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] now_ms, [34:32] slot_id, [37:35] new_mode, [39:38] zero
    input  logic [lpc_pkg::IN_DATA_W-1:0]   s_tdata,
    // [0] func
    input  logic                            s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] slot_index, [3] drive_written, [4] drive_on, [5] brightness_write,
    // [13:6] brightness, [16:14] slot_mode, [17] status, [23:18] zero
    output logic [lpc_pkg::OUT_DATA_W-1:0]  m_tdata,
    // [0] kind
    output logic                            m_tuser,
    output logic                            m_tlast,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lpc_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SLOT = 2'd2;
    localparam logic [1:0] ST_SET  = 2'd3;

    logic [1:0] state_reg, state_next;

    // configuration registers
    logic [7:0] present_reg;
    logic [7:0] dimmable_reg;
    logic [3:0] static_count_reg;
    logic       cfg_write;
    logic [1:0] cfg_index;

    // latched item
    logic                        func_reg;
    logic [lpc_pkg::TIME_W-1:0]  now_reg;
    logic [lpc_pkg::SLOT_W-1:0]  id_reg;
    logic [lpc_pkg::MODE_W-1:0]  new_mode_reg;

    logic [lpc_pkg::SLOT_W-1:0]  idx_reg;

    // slot storage
    logic [lpc_pkg::MODE_W-1:0]  mode_reg   [lpc_pkg::SLOT_COUNT];
    logic [lpc_pkg::TIME_W-1:0]  time_reg   [lpc_pkg::SLOT_COUNT];
    logic [lpc_pkg::FLASH_W-1:0] flash_reg  [lpc_pkg::SLOT_COUNT];
    logic [lpc_pkg::LEVEL_W-1:0] level_reg  [lpc_pkg::SLOT_COUNT];
    logic                        rising_reg [lpc_pkg::SLOT_COUNT];

    // output register
    logic                            m_valid_reg;
    logic [lpc_pkg::OUT_DATA_W-1:0]  m_data_reg;
    logic                            m_user_reg;
    logic                            m_last_reg;

    logic                  in_xfer;
    logic                  out_free;
    logic                  div_busy;
    lpc_pkg::phase_t       phase;
    lpc_pkg::slot_state_t  cur_slot, nxt_slot;
    lpc_pkg::drive_t       drive;
    logic                  set_bad;
    logic                  slot_step;
    logic                  set_step;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];
    assign pready    = 1'b1;

    always_comb begin
        unique case (cfg_index)
            2'(lpc_pkg::REG_PRESENT):  prdata = {24'd0, present_reg};
            2'(lpc_pkg::REG_DIMMABLE): prdata = {24'd0, dimmable_reg};
            2'(lpc_pkg::REG_STATIC):   prdata = {28'd0, static_count_reg};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg      <= '0;
            dimmable_reg     <= '0;
            static_count_reg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                2'(lpc_pkg::REG_PRESENT):  present_reg      <= pwdata[7:0];
                2'(lpc_pkg::REG_DIMMABLE): dimmable_reg     <= pwdata[7:0];
                2'(lpc_pkg::REG_STATIC):   static_count_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    lpc_phase_div u_phase_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_xfer && s_tuser == lpc_pkg::FUNC_UPDATE),
        .now_ms  (s_tdata[31:0]),
        .busy    (div_busy),
        .phase   (phase)
    );

    assign cur_slot.mode      = mode_reg[idx_reg];
    assign cur_slot.last_time = time_reg[idx_reg];
    assign cur_slot.flash     = flash_reg[idx_reg];
    assign cur_slot.level     = level_reg[idx_reg];
    assign cur_slot.rising    = rising_reg[idx_reg];

    lpc_slot_alu u_slot_alu (
        .present  (present_reg[idx_reg]),
        .dimmable (dimmable_reg[idx_reg]),
        .now_ms   (now_reg),
        .phase    (phase),
        .cur      (cur_slot),
        .nxt      (nxt_slot),
        .drive    (drive)
    );

    assign set_bad = ({1'b0, id_reg} >= static_count_reg)
                  || ({1'b0, id_reg} >= 4'(lpc_pkg::SLOT_COUNT));
    assign slot_step = (state_reg == ST_SLOT) && out_free;
    assign set_step  = (state_reg == ST_SET) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = (s_tuser == lpc_pkg::FUNC_SET) ? ST_SET : ST_DIV;
                end
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_SLOT;
                end
            end
            ST_SLOT: begin
                if (out_free && idx_reg == lpc_pkg::SLOT_W'(lpc_pkg::SLOT_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SET: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (in_xfer) begin
                idx_reg <= '0;
            end else if (slot_step) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            func_reg     <= s_tuser;
            now_reg      <= s_tdata[31:0];
            id_reg       <= s_tdata[34:32];
            new_mode_reg <= s_tdata[37:35];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lpc_pkg::SLOT_COUNT; i++) begin
                mode_reg[i]   <= lpc_pkg::MODE_OFF;
                time_reg[i]   <= '0;
                flash_reg[i]  <= '0;
                level_reg[i]  <= '0;
                rising_reg[i] <= 1'b1;
            end
        end else if (slot_step) begin
            mode_reg[idx_reg]   <= nxt_slot.mode;
            time_reg[idx_reg]   <= nxt_slot.last_time;
            flash_reg[idx_reg]  <= nxt_slot.flash;
            level_reg[idx_reg]  <= nxt_slot.level;
            rising_reg[idx_reg] <= nxt_slot.rising;
        end else if (set_step && !set_bad && func_reg == lpc_pkg::FUNC_SET) begin
            mode_reg[id_reg] <= new_mode_reg;
            time_reg[id_reg] <= now_reg;
            if (new_mode_reg == lpc_pkg::MODE_FLASH) begin
                flash_reg[id_reg] <= '0;
            end
            if (new_mode_reg == lpc_pkg::MODE_BREATH) begin
                level_reg[id_reg]  <= '0;
                rising_reg[id_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (slot_step || set_step) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_step) begin
            m_data_reg <= {6'd0, lpc_pkg::STATUS_OK, nxt_slot.mode, drive.br, drive.bw,
                           drive.on, drive.wr, idx_reg};
            m_user_reg <= lpc_pkg::KIND_DRIVE;
            m_last_reg <= (idx_reg == lpc_pkg::SLOT_W'(lpc_pkg::SLOT_COUNT - 1));
        end else if (set_step) begin
            if (set_bad) begin
                // invalid id reports the stored mode untouched
                m_data_reg <= {6'd0, lpc_pkg::STATUS_BAD, mode_reg[id_reg], 8'd0, 3'd0, id_reg};
            end else begin
                m_data_reg <= {6'd0, lpc_pkg::STATUS_OK, new_mode_reg, 8'd0, 3'd0, id_reg};
            end
            m_user_reg <= lpc_pkg::KIND_ACK;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule
